// ===== hdl/r3tb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3tb_pkg
// Shared types and constants of the radix-3 twiddle butterfly.
// ----------------------------------------------------------------------------
package r3tb_pkg;

  // Width of every butterfly output component.
  localparam int OUT_WIDTH = 19;

  // sqrt(3)/2 in Q1.15 and the fraction of the fixed constants.
  localparam logic signed [15:0] K_SQRT3_HALF = 16'sd28378;
  localparam int CONST_FRAC = 15;
  localparam int CONST_RND  = 1 << (CONST_FRAC - 1);

  // Load enables of the two complex multiplier stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

endpackage

// ===== hdl/r3tb_cmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3tb_cmul
// Two-stage complex multiplier: partial products in the first stage, then
// combination and round-half-up scaling by 2^(TW-1) in the second stage.
// ----------------------------------------------------------------------------
module r3tb_cmul #(
  parameter int SW = 16,
  parameter int TW = 16
) (
  input  logic                    clk_i,
  input  r3tb_pkg::stage_en_t     en_i,
  input  logic signed [SW-1:0]    a_re_i,
  input  logic signed [SW-1:0]    a_im_i,
  input  logic signed [TW-1:0]    w_re_i,
  input  logic signed [TW-1:0]    w_im_i,
  output logic signed [SW+1:0]    p_re_o,
  output logic signed [SW+1:0]    p_im_o
);

  localparam int MW = SW + TW;
  localparam int AW = MW + 1;
  localparam logic signed [AW-1:0] RND = {{(SW + 2){1'b0}}, 1'b1, {(TW - 2){1'b0}}};

  logic signed [MW-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [AW-1:0] acc_re, acc_im;
  logic signed [AW-1:0] sh_re, sh_im;
  logic signed [SW+1:0] p_re_q, p_im_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      rr_q <= MW'(a_re_i) * MW'(w_re_i);
      ii_q <= MW'(a_im_i) * MW'(w_im_i);
      ri_q <= MW'(a_re_i) * MW'(w_im_i);
      ir_q <= MW'(a_im_i) * MW'(w_re_i);
    end
  end

  always_comb begin
    acc_re = AW'(rr_q) - AW'(ii_q) + RND;
    acc_im = AW'(ri_q) + AW'(ir_q) + RND;
    sh_re  = acc_re >>> (TW - 1);
    sh_im  = acc_im >>> (TW - 1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      p_re_q <= sh_re[SW+1:0];
      p_im_q <= sh_im[SW+1:0];
    end
  end

  assign p_re_o = p_re_q;
  assign p_im_o = p_im_q;

endmodule

// ===== hdl/radix3_twiddle_butterfly.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix3_twiddle_butterfly
// Forward radix-3 decimation-in-time FFT butterfly in fixed point.
// ----------------------------------------------------------------------------
// The block takes one butterfly (three complex samples and two complex
// twiddles) per transfer and returns X0, X1 and X2 as 19-bit components.
// It accepts one transfer every clock cycle unless every stage is full and the
// output is stalled; a result passes the four register stages in turn: twiddle partial
// products, twiddle rounding, sum/difference with the sqrt(3)/2 multiply, and
// the final combination. Each stage holds its item while the next is full, so
// bubbles are squeezed out and input is taken as long as any stage can move.
// tlast travels with its butterfly.
module radix3_twiddle_butterfly #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int TWIDDLE_WIDTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, w1_re, w1_im, w2_re, w2_im, zero fill
  input  logic [((6*SAMPLE_WIDTH + 4*TWIDDLE_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  logic s_axis_tlast,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, zero fill
  output logic [((6*r3tb_pkg::OUT_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic m_axis_tlast
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TW   = TWIDDLE_WIDTH;
  localparam int OW   = r3tb_pkg::OUT_WIDTH;
  localparam int PW   = SW + 2;
  localparam int SUMW = SW + 3;
  localparam int RW   = SUMW + 16;
  localparam int WW   = (SW + 5 > OW) ? SW + 5 : OW;
  localparam int ODW  = ((6 * OW + 7) / 8) * 8;
  localparam logic signed [RW-1:0] ROT_RND = RW'(r3tb_pkg::CONST_RND);

  // Stage handshakes.
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;
  r3tb_pkg::stage_en_t mul_en;

  assign en4 = !v4_q || m_axis_tready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign s_axis_tready = en1;
  assign mul_en.s1 = en1;
  assign mul_en.s2 = en2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= s_axis_tvalid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // Input unpacking.
  logic signed [SW-1:0] x0_re, x0_im, x1_re, x1_im, x2_re, x2_im;
  logic signed [TW-1:0] w1_re, w1_im, w2_re, w2_im;

  assign x0_re = s_axis_tdata[0*SW +: SW];
  assign x0_im = s_axis_tdata[1*SW +: SW];
  assign x1_re = s_axis_tdata[2*SW +: SW];
  assign x1_im = s_axis_tdata[3*SW +: SW];
  assign x2_re = s_axis_tdata[4*SW +: SW];
  assign x2_im = s_axis_tdata[5*SW +: SW];
  assign w1_re = s_axis_tdata[6*SW + 0*TW +: TW];
  assign w1_im = s_axis_tdata[6*SW + 1*TW +: TW];
  assign w2_re = s_axis_tdata[6*SW + 2*TW +: TW];
  assign w2_im = s_axis_tdata[6*SW + 3*TW +: TW];

  // Twiddle multiplications, stages one and two.
  logic signed [PW-1:0] p1_re, p1_im, p2_re, p2_im;

  r3tb_cmul #(.SW(SW), .TW(TW)) u_cmul1 (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_re_i(x1_re),
    .a_im_i(x1_im),
    .w_re_i(w1_re),
    .w_im_i(w1_im),
    .p_re_o(p1_re),
    .p_im_o(p1_im)
  );

  r3tb_cmul #(.SW(SW), .TW(TW)) u_cmul2 (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_re_i(x2_re),
    .a_im_i(x2_im),
    .w_re_i(w2_re),
    .w_im_i(w2_im),
    .p_re_o(p2_re),
    .p_im_o(p2_im)
  );

  // x0 and tlast ride along the pipeline stages, x0 as far as stage three.
  logic signed [SW-1:0] a0r1_q, a0i1_q, a0r2_q, a0i2_q, a0r3_q, a0i3_q;
  logic                 last1_q, last2_q, last3_q, last4_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      a0r1_q  <= x0_re;
      a0i1_q  <= x0_im;
      last1_q <= s_axis_tlast;
    end
    if (en2) begin
      a0r2_q  <= a0r1_q;
      a0i2_q  <= a0i1_q;
      last2_q <= last1_q;
    end
    if (en3) begin
      a0r3_q  <= a0r2_q;
      a0i3_q  <= a0i2_q;
      last3_q <= last2_q;
    end
    if (en4) begin
      last4_q <= last3_q;
    end
  end

  // Stage three: sums, halves and the sqrt(3)/2 products of the differences.
  logic signed [SUMW-1:0] sum_r, sum_i, dif_r, dif_i;
  logic signed [SUMW:0]   inc_r, inc_i;
  logic signed [SUMW:0]   half_r, half_i;
  logic signed [SUMW-1:0] sum_r_q, sum_i_q, half_r_q, half_i_q;
  logic signed [RW-1:0]   rprod_r_q, rprod_i_q;

  always_comb begin
    sum_r  = SUMW'(p1_re) + SUMW'(p2_re);
    sum_i  = SUMW'(p1_im) + SUMW'(p2_im);
    dif_r  = SUMW'(p2_re) - SUMW'(p1_re);
    dif_i  = SUMW'(p2_im) - SUMW'(p1_im);
    // Halving with round half up is (s + 1) >> 1.
    inc_r  = (SUMW + 1)'(sum_r) + (SUMW + 1)'(1);
    inc_i  = (SUMW + 1)'(sum_i) + (SUMW + 1)'(1);
    half_r = inc_r >>> 1;
    half_i = inc_i >>> 1;
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      sum_r_q   <= sum_r;
      sum_i_q   <= sum_i;
      half_r_q  <= half_r[SUMW-1:0];
      half_i_q  <= half_i[SUMW-1:0];
      rprod_r_q <= RW'(dif_i) * RW'(r3tb_pkg::K_SQRT3_HALF);
      rprod_i_q <= RW'(dif_r) * RW'(r3tb_pkg::K_SQRT3_HALF);
    end
  end

  // Stage four: rounding of the rotation terms and the output combination.
  logic signed [RW-1:0] rot_r_w, rot_i_w;
  logic signed [WW-1:0] rot_r, rot_i, mid_r, mid_i;
  logic signed [WW-1:0] y0_re, y0_im, y1_re, y1_im, y2_re, y2_im;
  logic [ODW-1:0]       tdata_q;

  always_comb begin
    rot_r_w = (rprod_r_q + ROT_RND) >>> r3tb_pkg::CONST_FRAC;
    rot_i_w = (rprod_i_q + ROT_RND) >>> r3tb_pkg::CONST_FRAC;
    rot_r   = WW'(rot_r_w);
    rot_i   = WW'(rot_i_w);
    mid_r   = WW'(a0r3_q) - WW'(half_r_q);
    mid_i   = WW'(a0i3_q) - WW'(half_i_q);
    y0_re   = WW'(a0r3_q) + WW'(sum_r_q);
    y0_im   = WW'(a0i3_q) + WW'(sum_i_q);
    y1_re   = mid_r - rot_r;
    y1_im   = mid_i + rot_i;
    y2_re   = mid_r + rot_r;
    y2_im   = mid_i - rot_i;
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      tdata_q <= {{(ODW - 6*OW){1'b0}}, y2_im[OW-1:0], y2_re[OW-1:0], y1_im[OW-1:0],
                  y1_re[OW-1:0], y0_im[OW-1:0], y0_re[OW-1:0]};
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = last4_q;

  // An input transfer always lands in the first stage.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v1_q)
    else $error("input transfer did not reach the first stage");

  // An empty first stage never blocks the input.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready)
    else $error("input stalled with an empty first stage");

  // A blocked third stage keeps its item.
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !en4 |=> v3_q && $stable(rprod_r_q) && $stable(sum_r_q))
    else $error("third stage lost its item under stall");

  // With nothing behind it, a delivered result leaves the output empty.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !v3_q |=> !m_axis_tvalid)
    else $error("result repeated after its transfer");

endmodule

// ===== tb/r3_butterfly_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r3_butterfly_checker
// Scoreboard for the radix-3 twiddle butterfly.
// ----------------------------------------------------------------------------
// Watches both stream channels of the butterfly. For every input transfer it
// computes X0, X1 and X2 in fixed point and queues them. Every output transfer
// is compared field by field with the oldest queued butterfly. The zero fill
// of the output tdata is checked too.
module r3_butterfly_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_tvalid_i,
  input  logic         in_tready_i,
  // x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, w1_re, w1_im, w2_re, w2_im
  input  logic [159:0] in_tdata_i,
  input  logic         in_tlast_i,
  input  logic         out_tvalid_i,
  input  logic         out_tready_i,
  // y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, zero fill
  input  logic [((6*r3tb_pkg::OUT_WIDTH + 7) / 8) * 8 - 1:0] out_tdata_i,
  input  logic         out_tlast_i,
  output int           err_count_o,
  output int           pending_o
);

  localparam int OW      = r3tb_pkg::OUT_WIDTH;
  localparam int RES_W   = ((6*OW + 7) / 8) * 8;
  localparam int TW_FRAC = 15;

  typedef struct packed {
    logic             last;
    logic [5:0][OW-1:0] y;
  } bfly_out_t;

  bfly_out_t bfly_q[$];
  bfly_out_t want;
  int        errs  = 0;
  int        depth = 0;
  string     comp_name [6] = '{"y0_re", "y0_im", "y1_re", "y1_im", "y2_re", "y2_im"};

  assign err_count_o = errs;
  assign pending_o   = depth;

  function automatic longint sample_at(input logic [159:0] d, input int idx);
    longint v;
    v = $signed(d[16*idx +: 16]);
    return v;
  endfunction

  // Round half up, then arithmetic shift (floor) by the fraction width.
  function automatic longint round_q15(input longint v);
    return (v + r3tb_pkg::CONST_RND) >>> TW_FRAC;
  endfunction

  function automatic bfly_out_t butterfly(input logic [159:0] d, input logic last);
    longint a0r, a0i, a1r, a1i, a2r, a2i, t1r, t1i, t2r, t2i;
    longint p1r, p1i, p2r, p2i, sum_r, sum_i, dif_r, dif_i;
    longint half_r, half_i, rot_r, rot_i, mid_r, mid_i;
    longint k3;
    longint rnd;
    bfly_out_t r;
    a0r = sample_at(d, 0); a0i = sample_at(d, 1);
    a1r = sample_at(d, 2); a1i = sample_at(d, 3);
    a2r = sample_at(d, 4); a2i = sample_at(d, 5);
    t1r = sample_at(d, 6); t1i = sample_at(d, 7);
    t2r = sample_at(d, 8); t2i = sample_at(d, 9);
    k3  = longint'(r3tb_pkg::K_SQRT3_HALF);
    rnd = longint'(r3tb_pkg::CONST_RND);

    p1r = round_q15(a1r * t1r - a1i * t1i);
    p1i = round_q15(a1r * t1i + a1i * t1r);
    p2r = round_q15(a2r * t2r - a2i * t2i);
    p2i = round_q15(a2r * t2i + a2i * t2r);

    sum_r = p1r + p2r;
    sum_i = p1i + p2i;
    dif_r = p2r - p1r;
    dif_i = p2i - p1i;

    half_r = (sum_r * rnd + rnd) >>> r3tb_pkg::CONST_FRAC;
    half_i = (sum_i * rnd + rnd) >>> r3tb_pkg::CONST_FRAC;
    rot_r  = (dif_i * k3 + rnd) >>> r3tb_pkg::CONST_FRAC;
    rot_i  = (dif_r * k3 + rnd) >>> r3tb_pkg::CONST_FRAC;

    mid_r = a0r - half_r;
    mid_i = a0i - half_i;

    r.y[0] = OW'(a0r + sum_r);
    r.y[1] = OW'(a0i + sum_i);
    r.y[2] = OW'(mid_r - rot_r);
    r.y[3] = OW'(mid_i + rot_i);
    r.y[4] = OW'(mid_r + rot_r);
    r.y[5] = OW'(mid_i - rot_i);
    r.last = last;
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_tvalid_i && in_tready_i) begin
        bfly_q.push_back(butterfly(in_tdata_i, in_tlast_i));
      end
      if (out_tvalid_i && out_tready_i) begin
        if (bfly_q.size() == 0) begin
          $error("output transfer with no butterfly outstanding");
          errs++;
        end else begin
          want = bfly_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (out_tdata_i[OW*k +: OW] !== want.y[k]) begin
              $error("%s: expected %0d, got %0d", comp_name[k],
                     $signed(want.y[k]), $signed(out_tdata_i[OW*k +: OW]));
              errs++;
            end
          end
          if (out_tlast_i !== want.last) begin
            $error("last_out: expected %0d, got %0d", want.last, out_tlast_i);
            errs++;
          end
          if (out_tdata_i[RES_W-1:6*OW] !== '0) begin
            $error("zero fill: expected 0, got %0h", out_tdata_i[RES_W-1:6*OW]);
            errs++;
          end
        end
      end
      depth = bfly_q.size();
    end
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stream testbench for the radix-3 twiddle butterfly.
// ----------------------------------------------------------------------------
// Sends a directed set of butterflies (full-scale samples and twiddles, unit
// and imaginary twiddles, rounding ties on the products, the halving and the
// sqrt(3)/2 scaling) and then random batches closed by tlast. Both sides stall
// at random, with one stretch at full rate. The checker does the prediction.
module tb;

  localparam int RES_W      = ((6*r3tb_pkg::OUT_WIDTH + 7) / 8) * 8;
  localparam int N_RANDOM   = 600;
  localparam int FULL_START = 200;
  localparam int FULL_STOP  = 350;

  logic             clk_i         = 1'b0;
  logic             rst_n         = 1'b0;
  logic             s_tvalid      = 1'b0;
  logic             s_tready;
  logic [159:0]     s_tdata       = '0;
  logic             s_tlast       = 1'b0;
  logic             m_tvalid;
  logic             m_tready      = 1'b0;
  logic [RES_W-1:0] m_tdata;
  logic             m_tlast;

  int  err_count;
  int  pending;
  bit  full_rate = 1'b0;
  int  n_directed = 0;
  int  n_random   = 0;
  int  batches    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  radix3_twiddle_butterfly uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tlast  (s_tlast),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast)
  );

  r3_butterfly_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .in_tvalid_i  (s_tvalid),
    .in_tready_i  (s_tready),
    .in_tdata_i   (s_tdata),
    .in_tlast_i   (s_tlast),
    .out_tvalid_i (m_tvalid),
    .out_tready_i (m_tready),
    .out_tdata_i  (m_tdata),
    .out_tlast_i  (m_tlast),
    .err_count_o  (err_count),
    .pending_o    (pending)
  );

  // Receiver back-pressure: about a third of the cycles stalled.
  always @(negedge clk_i) begin
    m_tready <= full_rate || ($urandom_range(0, 99) >= 33);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic push_butterfly(input logic [159:0] d, input logic last);
    while (!full_rate && $urandom_range(0, 99) < 33) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  task automatic send_fields(input int x0r, x0i, x1r, x1i, x2r, x2i,
                             input int w1r, w1i, w2r, w2i, input logic last);
    logic [159:0] d;
    d = {w2i[15:0], w2r[15:0], w1i[15:0], w1r[15:0], x2i[15:0], x2r[15:0],
         x1i[15:0], x1r[15:0], x0i[15:0], x0r[15:0]};
    push_butterfly(d, last);
    n_directed++;
  endtask

  // Mostly full-range values, with extremes and tiny values mixed in.
  function automatic logic [15:0] rand_component();
    int sel;
    int corner [6] = '{-32768, -32767, -1, 0, 1, 32767};
    sel = $urandom_range(0, 99);
    if (sel < 70) return 16'($urandom_range(0, 65535));
    if (sel < 85) return 16'(corner[$urandom_range(0, 5)]);
    return 16'($urandom_range(0, 8) - 4);
  endfunction

  initial begin
    logic [159:0] d;
    int           run_len;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // Directed butterflies.
    send_fields(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
    send_fields(32767, 32767, 32767, 32767, 32767, 32767,
                32767, 32767, 32767, 32767, 1'b1);
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768, -32768, 1'b0);
    // Near-unit twiddles (32767) pass the samples through almost unchanged.
    send_fields(-32768, -32768, -32768, -32768, -32768, -32768,
                32767, 0, 32767, 0, 1'b0);
    send_fields(32767, 32767, 32767, -32768, -32768, 32767,
                32767, 0, 32767, 0, 1'b1);
    // Largest product magnitudes, pushing the outputs to their widest.
    send_fields(32767, 32767, -32768, -32768, -32768, -32768,
                -32768, -32768, -32768, -32768, 1'b0);
    send_fields(-32768, -32768, -32768, 32767, 32767, -32768,
                -32768, -32768, 32767, 32767, 1'b0);
    send_fields(32767, -32768, -32768, -32768, 32767, 32767,
                -32768, 32767, 32767, -32768, 1'b1);
    // Imaginary and negative unit twiddles.
    send_fields(1000, -2000, 12345, -6789, -23456, 7890, 0, 32767, 0, -32768, 1'b0);
    send_fields(-1000, 2000, -12345, 6789, 23456, -7890, -32768, 0, 0, 32767, 1'b0);
    // Product rounding ties: exactly one half, positive and negative.
    send_fields(0, 0, 1, 0, 0, 0, 16384, 0, 0, 0, 1'b0);
    send_fields(0, 0, -1, 0, 0, 0, 16384, 0, 0, 0, 1'b0);
    send_fields(0, 0, 0, 1, 0, -1, 0, 16384, 0, 16384, 1'b0);
    send_fields(0, 0, 3, 0, 0, 0, 16384, 0, 0, 0, 1'b1);
    // Halving of odd sums and sqrt(3)/2 of small differences.
    send_fields(5, -5, 1, 0, 0, 0, 32767, 0, 0, 0, 1'b0);
    send_fields(5, -5, -1, 0, 0, 0, 32767, 0, 0, 0, 1'b0);
    send_fields(0, 0, 0, 1, 0, 0, 32767, 0, 0, 0, 1'b0);
    send_fields(0, 0, 3, -3, -2, 2, 32767, 0, 32767, 0, 1'b0);
    // Alternating bit patterns on every field.
    send_fields(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1);
    send_fields(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 1'b0);

    // Random batches, each closed by tlast.
    while (n_random < N_RANDOM) begin
      run_len = $urandom_range(1, 16);
      for (int i = 0; i < run_len && n_random < N_RANDOM; i++) begin
        full_rate = (n_random >= FULL_START) && (n_random < FULL_STOP);
        for (int f = 0; f < 10; f++) d[16*f +: 16] = rand_component();
        push_butterfly(d, (i == run_len - 1) || (n_random == N_RANDOM - 1));
        n_random++;
      end
      batches++;
    end
    s_tvalid <= 1'b0;
    full_rate = 1'b0;

    wait (pending == 0);
    repeat (16) @(posedge clk_i);
    $display("Ran %0d directed and %0d random butterflies in %0d batches,",
             n_directed, n_random, batches);
    $display("with random stalls on both sides and one stretch at full rate.");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timed out waiting for butterfly results.");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/r3tb_pkg.sv
hdl/r3tb_cmul.sv
hdl/radix3_twiddle_butterfly.sv
tb/r3_butterfly_checker.sv
tb/tb.sv
